### hw/rtl/nssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nssd_pkg
// shared types and constants of the nrzi slope sync deframer
// ----------------------------------------------------------------------------
package nssd_pkg;

	localparam int unsigned WORD_BITS  = 10;
	localparam int unsigned SYNC_BITS  = 9;
	localparam int unsigned COUNT_BITS = 4;

	localparam logic [SYNC_BITS-1:0]  SYNC_MASK    = 9'h1ff;
	localparam logic [SYNC_BITS-1:0]  SYNC_PATTERN = 9'h111;
	localparam logic [COUNT_BITS-1:0] WORD_PERIOD  = 4'd10;

	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_CARRIER = 1'b1;

	typedef struct packed {
		logic sample_step;
		logic carrier_lost;
	} ctrl_t;

	typedef struct packed {
		logic                 emit;
		logic [WORD_BITS-1:0] word;
		logic                 is_sync;
	} frame_t;

endpackage

### hw/rtl/nssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nssd_if
// sample and word stream channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface nssd_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           carrier_present;

	modport source (output valid, output cmd, output sample, output carrier_present,
		input ready);
	modport sink (input valid, input cmd, input sample, input carrier_present,
		output ready);
endinterface

interface nssd_word_if;
	logic                          valid;
	logic                          ready;
	logic [nssd_pkg::WORD_BITS-1:0] word;
	logic                          is_sync;

	modport source (output valid, output word, output is_sync, input ready);
	modport sink (input valid, input word, input is_sync, output ready);
endinterface

### hw/rtl/nssd_slope_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nssd_slope_decoder
// sample history and nrzi bit decision from the signs of two slopes
// ----------------------------------------------------------------------------
module nssd_slope_decoder #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nssd_pkg::ctrl_t                ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           dec_bit
);
	import nssd_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] older_q;
	logic signed [SAMPLE_WIDTH-1:0] newer_q;
	logic                           rise_a;
	logic                           rise_b;

	assign rise_a  = newer_q > older_q;
	assign rise_b  = sample > newer_q;
	assign dec_bit = rise_a ^ rise_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
		end else if (ctrl.carrier_lost) begin
			older_q <= '0;
			newer_q <= '0;
		end else if (ctrl.sample_step) begin
			older_q <= newer_q;
			newer_q <= sample;
		end
	end

endmodule

### hw/rtl/nssd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nssd_framer
// bit window, sync search and word period counter
// ----------------------------------------------------------------------------
module nssd_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  nssd_pkg::ctrl_t  ctrl,
	input  logic             dec_bit,
	output nssd_pkg::frame_t frame
);
	import nssd_pkg::*;

	logic                  synced_q;
	logic [WORD_BITS-1:0]  window_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [WORD_BITS-1:0]  window_nxt;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  sync_hit;

	assign window_nxt = {window_q[SYNC_BITS-1:0] & SYNC_MASK, dec_bit};
	assign sync_hit   = (window_nxt[SYNC_BITS-1:0] & SYNC_MASK) == SYNC_PATTERN;
	assign count_inc  = count_q + COUNT_BITS'(1);

	always_comb begin
		frame.word    = window_nxt;
		frame.is_sync = sync_hit;
		frame.emit    = sync_hit || (synced_q && count_inc == WORD_PERIOD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			window_q <= '0;
			count_q  <= '0;
		end else if (ctrl.carrier_lost) begin
			synced_q <= 1'b0;
			window_q <= '0;
			count_q  <= '0;
		end else if (ctrl.sample_step) begin
			window_q <= window_nxt;
			if (sync_hit) begin
				synced_q <= 1'b1;
				count_q  <= '0;
			end else if (synced_q) begin
				count_q <= (count_inc == WORD_PERIOD) ? '0 : count_inc;
			end
		end
	end

endmodule

### hw/rtl/nrzi_slope_sync_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrzi_slope_sync_deframer
// nrzi decoding of read samples by slope sign, sync search and word framing
//
//   channel   direction  payload                         transaction
//   samples   sink       cmd, sample, carrier_present    valid && ready
//   words     source     word, is_sync                   valid && ready
//
// one item per cycle while the words channel is not stalled; an item waits in the
// input register until it can go, and its word, if any, is loaded into the result
// register on the edge on which the item leaves the input register
// arst_n clears the sample history, window, counter and sync state
// a stalled words channel holds the input register only when it carries an
// item that emits a word; other items keep flowing
// ----------------------------------------------------------------------------
module nrzi_slope_sync_deframer #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	nssd_sample_if.sink  samples,
	nssd_word_if.source  words
);
	import nssd_pkg::*;

	logic                           valid_s1;
	logic                           cmd_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           carrier_s1;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 is_sync_q;

	ctrl_t  ctrl;
	frame_t frame;
	logic   dec_bit;
	logic   emit;
	logic   go_s1;

	assign emit  = valid_s1 && (cmd_s1 == CMD_SAMPLE) && frame.emit;
	assign go_s1 = valid_s1 && (!emit || !out_valid_q || words.ready);

	assign ctrl.sample_step  = go_s1 && (cmd_s1 == CMD_SAMPLE);
	assign ctrl.carrier_lost = go_s1 && (cmd_s1 == CMD_CARRIER) && !carrier_s1;

	assign samples.ready = !valid_s1 || go_s1;

	nssd_slope_decoder #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample_s1),
		.dec_bit(dec_bit)
	);

	nssd_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.dec_bit(dec_bit),
		.frame  (frame)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			cmd_s1     <= samples.cmd;
			sample_s1  <= samples.sample;
			carrier_s1 <= samples.carrier_present;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			word_q    <= frame.word;
			is_sync_q <= frame.is_sync;
		end
	end

	assign words.valid   = out_valid_q;
	assign words.word    = word_q;
	assign words.is_sync = is_sync_q;

endmodule

### hw/rtl/nssd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nssd_checker
// port level checks of the nrzi slope sync deframer
// ----------------------------------------------------------------------------
module nssd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           in_cmd,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [nssd_pkg::WORD_BITS-1:0] out_word,
	input logic                           out_is_sync
);
	import nssd_pkg::*;

	// stalled word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_is_sync))
		else $error("stalled word changed");

	// a sync word carries the pattern in its low bits
	a_sync_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_sync |-> (out_word[SYNC_BITS-1:0] & SYNC_MASK) == SYNC_PATTERN)
		else $error("sync word without sync pattern");

	// a carrier transaction never produces a word
	a_carrier_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_CARRIER |=> ##1 !$rose(out_valid))
		else $error("word after carrier transaction");

endmodule

bind nrzi_slope_sync_deframer nssd_checker u_nssd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.in_cmd     (samples.cmd),
	.out_valid  (words.valid),
	.out_ready  (words.ready),
	.out_word   (words.word),
	.out_is_sync(words.is_sync)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nrzi slope sync deframer
//
// sample transactions come from a queue that is filled up front: a short
// directed part (carrier events, full-scale samples, a sync pattern and one
// periodic word), then random traffic. most of the random traffic is sync
// patterns built from chosen slope signs and followed by random bits. the
// rest is raw noise, cut-off sync patterns and carrier reports and losses.
// a bit-level decoder in the bench predicts every word. the monitor compares
// each word transaction in order against those predictions. both channels
// idle at random, with bursts of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb_top;
	import nssd_pkg::*;

	localparam int SAMPLE_W     = 16;
	localparam int RANDOM_ITEMS = 1800;
	localparam int MAX_IDLE     = 19;
	localparam int DRAIN_CYCLES = 40;
	localparam int FLUSH_LIMIT  = 2000;

	typedef struct {
		logic                       cmd;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       carrier_present;
	} sample_item_t;

	typedef struct {
		logic [WORD_BITS-1:0] word;
		logic                 is_sync;
	} word_item_t;

	logic clk = 1'b0;
	logic arst_n;

	nssd_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) samples_ch ();
	nssd_word_if words_ch ();

	nrzi_slope_sync_deframer #(.SAMPLE_WIDTH(SAMPLE_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.words  (words_ch)
	);

	always #5 clk = ~clk;

	sample_item_t pending_items[$];
	word_item_t   expected_words[$];

	int n_accepted     = 0;
	int n_words        = 0;
	int n_sync_words   = 0;
	int n_carrier_lost = 0;
	int n_errors       = 0;

	// decoder state, equal to the reset state at time zero
	logic                       dec_synced = 1'b0;
	logic [WORD_BITS-1:0]       dec_window = '0;
	logic [COUNT_BITS-1:0]      dec_count  = '0;
	logic signed [SAMPLE_W-1:0] dec_older  = '0;
	logic signed [SAMPLE_W-1:0] dec_newer  = '0;

	// slope history as seen by the stimulus generator
	int gen_older = 0;
	int gen_newer = 0;
	int gen_live  = 0;

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 30)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic decode_item(input sample_item_t it);
		logic       rise_prev;
		logic       rise_new;
		word_item_t res;
		if (it.cmd == CMD_CARRIER) begin
			if (!it.carrier_present) begin
				dec_synced = 1'b0;
				dec_window = '0;
				dec_count  = '0;
				dec_older  = '0;
				dec_newer  = '0;
				n_carrier_lost++;
			end
			return;
		end
		rise_prev  = dec_newer > dec_older;
		rise_new   = it.sample > dec_newer;
		dec_window = {dec_window[WORD_BITS-2:0], rise_prev ^ rise_new};
		res.word    = dec_window;
		res.is_sync = 1'b0;
		if ((dec_window[SYNC_BITS-1:0] & SYNC_MASK) == SYNC_PATTERN) begin
			dec_count   = '0;
			dec_synced  = 1'b1;
			res.is_sync = 1'b1;
			expected_words.push_back(res);
		end else if (dec_synced) begin
			dec_count = dec_count + 1'b1;
			if (dec_count == WORD_PERIOD) begin
				dec_count = '0;
				expected_words.push_back(res);
			end
		end
		dec_older = dec_newer;
		dec_newer = it.sample;
	endtask

	task automatic check_word(input logic [WORD_BITS-1:0] word, input logic is_sync);
		word_item_t want;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word %h is_sync %b", word, is_sync));
			return;
		end
		want = expected_words.pop_front();
		n_words++;
		if (want.is_sync)
			n_sync_words++;
		if (word !== want.word)
			report_mismatch($sformatf("word %h, expected %h", word, want.word));
		if (is_sync !== want.is_sync)
			report_mismatch($sformatf("is_sync %b, expected %b on word %h",
				is_sync, want.is_sync, want.word));
	endtask

	task automatic queue_item(input logic cmd, input int value, input logic present);
		sample_item_t it;
		it.cmd             = cmd;
		it.sample          = value[SAMPLE_W-1:0];
		it.carrier_present = present;
		pending_items.push_back(it);
		if (cmd == CMD_SAMPLE) begin
			gen_older = gen_newer;
			gen_newer = int'(it.sample);
			gen_live++;
		end else if (!present) begin
			gen_older = 0;
			gen_newer = 0;
			gen_live++;
		end
	endtask

	// picks a sample whose slope against the last one decodes to the given bit, where the sample range allows
	task automatic queue_bit(input logic b);
		int   amp;
		int   room;
		int   value;
		logic want_rise;
		amp       = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 300);
		want_rise = (gen_newer > gen_older) ^ b;
		if (want_rise) begin
			room  = 32767 - gen_newer;
			value = (room == 0) ? gen_newer
				: gen_newer + int'($urandom_range(1, (room < amp) ? room : amp));
		end else begin
			room  = gen_newer + 32768;
			value = gen_newer - int'($urandom_range(0, (room < amp) ? room : amp));
		end
		queue_item(CMD_SAMPLE, value, 1'($urandom_range(0, 1)));
	endtask

	task automatic queue_sync();
		for (int i = SYNC_BITS - 1; i >= 0; i--)
			queue_bit(SYNC_PATTERN[i]);
	endtask

	// sample channel driver
	sample_item_t drv_item;
	int           drv_gap  = 0;
	int           drv_sent = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_ch.valid           <= 1'b0;
			samples_ch.cmd             <= CMD_SAMPLE;
			samples_ch.sample          <= '0;
			samples_ch.carrier_present <= 1'b1;
			drv_gap = 0;
		end else begin
			if (samples_ch.valid && samples_ch.ready) begin
				decode_item(drv_item);
				n_accepted++;
			end
			if (!samples_ch.valid || samples_ch.ready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					samples_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					drv_item = pending_items.pop_front();
					samples_ch.valid           <= 1'b1;
					samples_ch.cmd             <= drv_item.cmd;
					samples_ch.sample          <= drv_item.sample;
					samples_ch.carrier_present <= drv_item.carrier_present;
					drv_sent++;
					drv_gap = ((drv_sent % 400) < 80) ? 0 : $urandom_range(0, MAX_IDLE);
				end else begin
					samples_ch.valid <= 1'b0;
				end
			end
		end
	end

	// word channel monitor
	int mon_stall = 0;
	int mon_seen  = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_ch.ready <= 1'b0;
			mon_stall = 0;
		end else begin
			if (words_ch.valid && words_ch.ready) begin
				check_word(words_ch.word, words_ch.is_sync);
				mon_seen++;
				mon_stall = ((mon_seen % 300) < 60) ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (mon_stall > 0) begin
				mon_stall--;
				words_ch.ready <= 1'b0;
			end else begin
				words_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int kind;
		int n;
		int total;
		arst_n = 1'b0;

		// directed part
		queue_item(CMD_CARRIER, $urandom, 1'b1);
		queue_item(CMD_SAMPLE, 32767, 1'b0);
		queue_item(CMD_SAMPLE, -32768, 1'b1);
		queue_item(CMD_SAMPLE, -32768, 1'b0);
		queue_item(CMD_SAMPLE, 32767, 1'b1);
		queue_sync();
		repeat (WORD_BITS)
			queue_bit(1'($urandom_range(0, 1)));
		queue_item(CMD_CARRIER, 0, 1'b0);

		// random part
		gen_live = 0;
		while (gen_live < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				queue_sync();
				n = $urandom_range(5, 45);
				repeat (n)
					queue_bit(1'($urandom_range(0, 1)));
			end else if (kind < 78) begin
				n = $urandom_range(1, 20);
				repeat (n)
					queue_item(CMD_SAMPLE, $urandom, 1'($urandom_range(0, 1)));
			end else if (kind < 88) begin
				n = $urandom_range(1, SYNC_BITS - 1);
				for (int i = 0; i < n; i++)
					queue_bit(SYNC_PATTERN[SYNC_BITS-1-i]);
				queue_bit(!SYNC_PATTERN[SYNC_BITS-1-n]);
			end else if (kind < 95) begin
				queue_item(CMD_CARRIER, $urandom, 1'b1);
			end else begin
				queue_item(CMD_CARRIER, $urandom, 1'b0);
			end
		end
		total = pending_items.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == total);
		for (int c = 0; c < FLUSH_LIMIT && expected_words.size() != 0; c++)
			@(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived",
				expected_words.size()));
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sample transactions, %0d carrier losses", total, n_carrier_lost);
		$display("%0d words checked, %0d of them sync, %0d errors",
			n_words, n_sync_words, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout after %0d accepted sample transactions", n_accepted);
		$display("FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/nssd_pkg.sv
hw/rtl/nssd_if.sv
hw/rtl/nssd_slope_decoder.sv
hw/rtl/nssd_framer.sv
hw/rtl/nrzi_slope_sync_deframer.sv
hw/rtl/nssd_checker.sv
tb/tb_top.sv
